/* src/assert_macros.svh */
// assertion macros used by log_average_luminance
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LAL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition never holds
`define LAL_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

/* src/lal_pkg.sv */
// types, constants and the exp2 root table function for log_average_luminance
// no dependencies
package lal_pkg;

  localparam logic [15:0] COEF_R  = 16'd13933;
  localparam logic [15:0] COEF_G  = 16'd46871;
  localparam logic [15:0] COEF_B  = 16'd4732;
  localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic load;
    logic lum;
    logic log_step;
    logic acc;
    logic div_init;
    logic div_step;
    logic mean;
    logic exp_step;
    logic out_load;
  } lal_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic out_busy;
  } lal_stat_t;

  // floor square root of a 64-bit value
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    x   = x_in;
    res = '0;
    for (int j = 31; j >= 0; j--) begin
      bt = 64'd1 << (2 * j);
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // 2^(2^-(k+1)) in q1.30, each a floor sqrt of the previous one
  function automatic logic [31:0] root_of(input int k);
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int n = 0; n <= k; n++) begin
      root = isqrt64(root << 30);
    end
    return root[31:0];
  endfunction

endpackage

/* src/log_average_luminance.sv */
// log_average_luminance: one pixel enters while the block is idle and goes
// through luminance, log2 (one log2 fraction bit per cycle from a
// single 32x32 squarer) and accumulate. The last pixel of a frame then runs
// the divide (one quotient bit a cycle) and exp2 (one root product a cycle)
// and the output load. The result waits in an output register while the next
// frame's pixels are taken. Pixels past 2^MAX_PIXELS_LOG2 in a frame are ignored.
// depends on lal_pkg, lal_ctrl, lal_dp and assert_macros.svh
`include "assert_macros.svh"
module log_average_luminance #(
  parameter int MAX_PIXELS_LOG2 = 22,
  parameter int LOG_FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // red, green, blue
  input  logic        s_axis_tlast,  // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // average_luminance
);
  import lal_pkg::*;

  localparam int SUM_W   = LOG_FRAC_BITS + 6 + MAX_PIXELS_LOG2;
  localparam int COUNT_W = MAX_PIXELS_LOG2 + 1;
  localparam int ITR_W   = $clog2(SUM_W + 1);

  lal_cmd_t           cmd;
  lal_stat_t          stat;
  logic [ITR_W-1:0]   itr;
  logic [COUNT_W-1:0] count;

  lal_ctrl #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS), .SUM_W(SUM_W), .ITR_W(ITR_W)
  ) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .stat_i(stat), .cmd_o(cmd), .itr_o(itr)
  );

  lal_dp #(
    .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2), .LOG_FRAC_BITS(LOG_FRAC_BITS),
    .SUM_W(SUM_W), .COUNT_W(COUNT_W), .ITR_W(ITR_W)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .itr_i(itr), .stat_o(stat),
    .red_i(s_axis_tdata[15:0]), .green_i(s_axis_tdata[31:16]),
    .blue_i(s_axis_tdata[47:32]), .last_i(s_axis_tlast),
    .avg_o(m_axis_tdata), .avg_valid_o(m_axis_tvalid),
    .avg_ready_i(m_axis_tready), .count_o(count)
  );

  `LAL_ASSERT_NEVER(a_count_bound, count > (COUNT_W'(1) << MAX_PIXELS_LOG2))
  `LAL_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready)
  `LAL_ASSERT_IMPL(a_acc_not_full, cmd.acc, !stat.full)

endmodule

/* src/lal_ctrl.sv */
// control state machine for log_average_luminance
// depends on lal_pkg
module lal_ctrl #(
  parameter int LOG_FRAC_BITS = 16,
  parameter int SUM_W         = 44,
  parameter int ITR_W         = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lal_pkg::lal_stat_t  stat_i,
  output lal_pkg::lal_cmd_t   cmd_o,
  output logic [ITR_W-1:0]    itr_o
);
  import lal_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LUM, ST_LOG, ST_ACC, ST_DINIT, ST_DIV, ST_MEAN, ST_EXP, ST_OUT
  } state_e;

  localparam logic [ITR_W-1:0] LOG_LAST = ITR_W'(LOG_FRAC_BITS - 1);
  localparam logic [ITR_W-1:0] DIV_LAST = ITR_W'(SUM_W - 1);

  state_e           state_q;
  logic [ITR_W-1:0] itr_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign itr_o      = itr_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.lum      = (state_q == ST_LUM);
    cmd_o.log_step = (state_q == ST_LOG);
    cmd_o.acc      = (state_q == ST_ACC) && !stat_i.full;
    cmd_o.div_init = (state_q == ST_DINIT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.mean     = (state_q == ST_MEAN);
    cmd_o.exp_step = (state_q == ST_EXP);
    cmd_o.out_load = (state_q == ST_OUT) && !stat_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      itr_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_LUM;
        end
        ST_LUM: begin
          itr_q   <= '0;
          state_q <= ST_LOG;
        end
        ST_LOG: begin
          itr_q <= itr_q + 1'b1;
          if (itr_q == LOG_LAST) state_q <= ST_ACC;
        end
        ST_ACC: begin
          state_q <= stat_i.last ? ST_DINIT : ST_IDLE;
        end
        ST_DINIT: begin
          itr_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          itr_q <= itr_q + 1'b1;
          if (itr_q == DIV_LAST) state_q <= ST_MEAN;
        end
        ST_MEAN: begin
          itr_q   <= '0;
          state_q <= ST_EXP;
        end
        ST_EXP: begin
          itr_q <= itr_q + 1'b1;
          if (itr_q == LOG_LAST) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!stat_i.out_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/lal_dp.sv */
// datapath for log_average_luminance: luminance, log2, sum, divider, exp2
// depends on lal_pkg
module lal_dp #(
  parameter int MAX_PIXELS_LOG2 = 22,
  parameter int LOG_FRAC_BITS   = 16,
  parameter int SUM_W           = 44,
  parameter int COUNT_W         = 23,
  parameter int ITR_W           = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lal_pkg::lal_cmd_t   cmd_i,
  input  logic [ITR_W-1:0]    itr_i,
  output lal_pkg::lal_stat_t  stat_o,
  input  logic [15:0]         red_i,
  input  logic [15:0]         green_i,
  input  logic [15:0]         blue_i,
  input  logic                last_i,
  output logic [23:0]         avg_o,
  output logic                avg_valid_o,
  input  logic                avg_ready_i,
  output logic [COUNT_W-1:0]  count_o
);
  import lal_pkg::*;

  localparam int LOG_W = LOG_FRAC_BITS + 6;
  localparam int T_W   = LOG_FRAC_BITS + 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1) << MAX_PIXELS_LOG2;
  localparam logic signed [SUM_W:0] T_BIAS = (SUM_W+1)'(16) << LOG_FRAC_BITS;

  logic [31:0] root_tbl [LOG_FRAC_BITS];
  for (genvar k = 0; k < LOG_FRAC_BITS; k++) begin : g_root
    assign root_tbl[k] = root_of(k);
  end

  logic [15:0] r_q, g_q, b_q;
  logic        last_q;
  logic [31:0] m_q;
  logic [4:0]  e_q;
  logic [LOG_FRAC_BITS-1:0] frac_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [COUNT_W-1:0]       count_q;
  logic        neg_q;
  logic [SUM_W-1:0]   dvd_q;
  logic [COUNT_W-1:0] rem_q;
  logic [T_W-LOG_FRAC_BITS-1:0] ti_q;
  logic [LOG_FRAC_BITS-1:0]     tf_q;
  logic [30:0] acc_q;
  logic [23:0] avg_q;
  logic        avg_valid_q;

  // luminance and normalization
  logic [32:0] wsum;
  logic [23:0] lum;
  logic [4:0]  msb;
  always_comb begin
    wsum = 33'(COEF_R * r_q) + 33'(COEF_G * g_q) + 33'(COEF_B * b_q) + 33'd128;
    lum  = wsum[31:8] + 24'd1;
    msb  = '0;
    for (int j = 0; j < 24; j++) begin
      if (lum[j]) msb = 5'(j);
    end
  end

  // one log2 fraction bit per squaring
  logic [63:0] sq;
  logic [32:0] sq_s;
  assign sq   = m_q * m_q;
  assign sq_s = sq[63:31];

  logic signed [LOG_W-1:0] log_val;
  assign log_val = {6'(e_q) - 6'd16, frac_q};

  // restoring divider step on magnitudes
  logic [COUNT_W:0] rem_sh;
  logic             q_bit;
  assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, count_q});

  // floor mean and exp2 argument
  logic [SUM_W-1:0]       q_adj;
  logic signed [SUM_W:0]  mean_s;
  logic signed [SUM_W:0]  t_s;
  always_comb begin
    q_adj  = dvd_q + SUM_W'(neg_q && (rem_q != '0));
    mean_s = neg_q ? -$signed({1'b0, q_adj}) : $signed({1'b0, q_adj});
    t_s    = mean_s + T_BIAS;
  end

  logic [61:0] prod;
  assign prod = acc_q * root_tbl[itr_i[$clog2(LOG_FRAC_BITS)-1:0]];

  logic [61:0] shifted;
  logic [61:0] v;
  assign shifted = 62'(acc_q) << ti_q;
  assign v       = shifted >> 30;

  assign stat_o.full     = (count_q >= COUNT_MAX);
  assign stat_o.last     = last_q;
  assign stat_o.out_busy = avg_valid_q && !avg_ready_i;
  assign avg_o           = avg_q;
  assign avg_valid_o     = avg_valid_q;
  assign count_o         = count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q    <= red_i;
      g_q    <= green_i;
      b_q    <= blue_i;
      last_q <= last_i;
    end
    if (cmd_i.lum) begin
      e_q    <= msb;
      m_q    <= 32'(lum) << (5'd31 - msb);
      frac_q <= '0;
    end
    if (cmd_i.log_step) begin
      frac_q <= {frac_q[LOG_FRAC_BITS-2:0], sq_s[32]};
      m_q    <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
    end
    if (cmd_i.div_init) begin
      neg_q <= sum_q[SUM_W-1];
      dvd_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
      rem_q <= q_bit ? COUNT_W'(rem_sh - {1'b0, count_q}) : rem_sh[COUNT_W-1:0];
    end
    if (cmd_i.mean) begin
      acc_q <= 31'h4000_0000;
      if (t_s < 0) begin
        ti_q <= '0;
        tf_q <= '0;
      end else begin
        ti_q <= t_s[T_W-1:LOG_FRAC_BITS];
        tf_q <= t_s[LOG_FRAC_BITS-1:0];
      end
    end
    if (cmd_i.exp_step) begin
      tf_q <= tf_q << 1;
      if (tf_q[LOG_FRAC_BITS-1]) acc_q <= prod[60:30];
    end
    if (cmd_i.out_load) begin
      avg_q <= (v > 62'(OUT_MAX)) ? OUT_MAX : v[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      avg_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        sum_q   <= sum_q + SUM_W'(log_val);
        count_q <= count_q + 1'b1;
      end else if (cmd_i.mean) begin
        sum_q   <= '0;
        count_q <= '0;
      end
      if (cmd_i.out_load) avg_valid_q <= 1'b1;
      else if (avg_ready_i) avg_valid_q <= 1'b0;
    end
  end

endmodule
